### hdl/imh_pkg.sv
// Package: widths, action and status codes, and the result record of the indexed min-heap.
`default_nettype none
package imh_pkg;
  localparam int CAPACITY   = 1024;
  localparam int KEY_BITS   = 32;
  localparam int VERT_BITS  = 10;
  localparam int SLOT_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS   = SLOT_BITS + 1;

  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_EXTRACT  = 2'd1;
  localparam logic [1:0] ACT_DECREASE = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_PRESENT  = 3'd3;
  localparam logic [2:0] ST_ABSENT   = 3'd4;
  localparam logic [2:0] ST_NOTSMALL = 3'd5;

  typedef struct packed {
    logic [2:0]          status;
    logic [VERT_BITS-1:0] vertex;
    logic [KEY_BITS-1:0] distance;
    logic                present;
    logic [CNT_BITS-1:0] count;
  } result_t;
endpackage
`default_nettype wire

### hdl/imh_out_reg.sv
// Output register: holds one result until the downstream side takes it.
`default_nettype none
module imh_out_reg
  import imh_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_data,
  output logic         full,
  input  wire logic    take,
  output result_t      data
);
  // Load on request, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) full && !take |=> full)
    else $error("result lost while waiting");
  assert property (@(posedge clk) disable iff (rst) full && !take && !load |=> $stable(data))
    else $error("waiting result changed");
  assert property (@(posedge clk) disable iff (rst) load |=> full)
    else $error("loaded result not held");
endmodule
`default_nettype wire

### hdl/indexed_min_heap.sv
// Top level: indexed binary min-heap with a sequenced sift unit over slot and position memories.
//
//  channel  | direction | handshake                  | payload
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | tdata: action, vertex_id, key_value
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata: status, out_vertex, out_distance,
//           |           |                             |        present, count
//
// Sift up steps through S_UP and S_UPC per level, sift down through S_DN, S_DNL and S_DNR
// (one compare unit, single-port memories). After reset a clearing pass writes all 1024
// position entries absent before the first transaction is taken. Reset is synchronous,
// active high. A stalled output holds the result; a new transaction is taken once the
// sequencer is idle and the register is free.
`default_nettype none
module indexed_min_heap
  import imh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] action, [11:2] vertex_id, [43:12] key_value, [47:44] zero
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] status, [12:3] out_vertex, [44:13] out_distance, [45] present,
  // [56:46] count, [63:57] zero
  output logic [63:0]      m_axis_tdata
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_POS   = 4'd2;  // position entry returned, decide
  localparam logic [3:0] S_DREAD = 4'd3;  // decrease: slot distance returned
  localparam logic [3:0] S_XROOT = 4'd4;  // extract: root returned
  localparam logic [3:0] S_XLAST = 4'd5;  // extract: last slot returned
  localparam logic [3:0] S_UP    = 4'd6;  // sift up: issue parent read
  localparam logic [3:0] S_UPC   = 4'd7;  // sift up: parent returned
  localparam logic [3:0] S_DN    = 4'd8;  // sift down: issue left child read
  localparam logic [3:0] S_DNL   = 4'd9;  // sift down: left child returned
  localparam logic [3:0] S_DNR   = 4'd10; // sift down: right child returned
  localparam logic [3:0] S_PUT   = 4'd11; // place the moving entry
  localparam logic [3:0] S_DONE  = 4'd12;

  localparam int VD = VERT_BITS + KEY_BITS;

  // Memories
  logic [VD-1:0]       heap_mem [CAPACITY];
  logic [CNT_BITS-1:0] pos_mem  [1 << VERT_BITS];   // MSB = valid

  logic [3:0]           state;
  logic [VERT_BITS-1:0] clr_idx;
  logic [1:0]           act;
  logic [VERT_BITS-1:0] vid;
  logic [KEY_BITS-1:0]  key;
  logic [CNT_BITS-1:0]  count;
  logic [SLOT_BITS-1:0] at;        // hole slot of the moving entry
  logic [VERT_BITS-1:0] cur_v;
  logic [KEY_BITS-1:0]  cur_d;
  logic [VERT_BITS-1:0] oth_v;     // left child held while the right one is read
  logic [KEY_BITS-1:0]  oth_d;
  logic                 lwin;      // left child beats the moving entry
  logic [2:0]           status;
  logic [VERT_BITS-1:0] ov;
  logic [KEY_BITS-1:0]  od;
  logic                 pres;

  // Memory ports, driven by the sequencer
  logic                 h_we, p_we;
  logic [SLOT_BITS-1:0] h_addr;
  logic [VD-1:0]        h_wdata, h_rdata;
  logic [VERT_BITS-1:0] p_addr;
  logic [CNT_BITS-1:0]  p_wdata, p_rdata;

  always_ff @(posedge clk) begin
    if (h_we) heap_mem[h_addr] <= h_wdata;
    h_rdata <= heap_mem[h_addr];
  end
  always_ff @(posedge clk) begin
    if (p_we) pos_mem[p_addr] <= p_wdata;
    p_rdata <= pos_mem[p_addr];
  end

  logic [VERT_BITS-1:0] rd_v;
  logic [KEY_BITS-1:0]  rd_d;
  assign rd_v = h_rdata[VD-1:KEY_BITS];
  assign rd_d = h_rdata[KEY_BITS-1:0];

  // Child indexes of at, widened so a compare against count is exact
  logic [CNT_BITS:0]    lc, rc;
  logic [SLOT_BITS-1:0] parent;
  logic                 has_lc, has_rc;
  assign lc     = {1'b0, at, 1'b1};
  assign rc     = {1'b0, at, 1'b0} + (CNT_BITS+1)'(2);
  assign parent = SLOT_BITS'((at - SLOT_BITS'(1)) >> 1);
  assign has_lc = lc < {1'b0, count};
  assign has_rc = rc < {1'b0, count};

  // Shared distance comparator
  logic [KEY_BITS-1:0] cmp_a, cmp_b;
  logic                lt;
  always_comb begin
    cmp_a = rd_d;
    cmp_b = cur_d;
    case (state)
      S_DREAD: begin cmp_a = key; cmp_b = rd_d; end
      S_UPC:   begin cmp_a = cur_d; cmp_b = rd_d; end
      S_DNR:   if (lwin) cmp_b = oth_d;
      default: ;
    endcase
  end
  assign lt = cmp_a < cmp_b;

  logic     res_full, res_load;
  result_t  res_in, res_q;
  assign s_axis_tready = (state == S_IDLE) && !res_full;

  // Sequencer: memory addresses and writes per state
  always_comb begin
    h_we = 1'b0; p_we = 1'b0;
    h_addr = at; h_wdata = {cur_v, cur_d};
    p_addr = vid; p_wdata = '0;
    res_load = 1'b0;
    case (state)
      S_CLEAR: begin p_we = 1'b1; p_addr = clr_idx; end
      S_IDLE:  p_addr = s_axis_tdata[11:2];
      S_POS: begin
        if (act == ACT_EXTRACT) h_addr = '0;
        else h_addr = p_rdata[SLOT_BITS-1:0];
      end
      S_XROOT: begin
        h_addr = SLOT_BITS'(count - CNT_BITS'(1));
        p_we = 1'b1; p_addr = rd_v; p_wdata = '0;
      end
      S_UP: h_addr = parent;
      S_UPC: if (lt) begin
        h_we = 1'b1; h_wdata = h_rdata;
        p_we = 1'b1; p_addr = rd_v; p_wdata = {1'b1, at};
      end
      S_DN: h_addr = lc[SLOT_BITS-1:0];
      S_DNL: begin
        if (has_rc) begin
          h_addr = rc[SLOT_BITS-1:0];
        end else if (lt) begin
          h_we = 1'b1; h_wdata = h_rdata;
          p_we = 1'b1; p_addr = rd_v; p_wdata = {1'b1, at};
        end
      end
      S_DNR: begin
        if (lt) begin
          h_we = 1'b1; h_wdata = h_rdata;
          p_we = 1'b1; p_addr = rd_v; p_wdata = {1'b1, at};
        end else if (lwin) begin
          h_we = 1'b1; h_wdata = {oth_v, oth_d};
          p_we = 1'b1; p_addr = oth_v; p_wdata = {1'b1, at};
        end
      end
      S_PUT: begin
        h_we = 1'b1;
        p_we = 1'b1; p_addr = cur_v; p_wdata = {1'b1, at};
      end
      S_DONE: res_load = 1'b1;
      default: ;
    endcase
  end

  // Sequencer: state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_idx <= '0; count <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (&clr_idx) state <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          act <= s_axis_tdata[1:0];
          vid <= s_axis_tdata[11:2];
          key <= s_axis_tdata[43:12];
          status <= ST_OK; ov <= '0; od <= '0;
          state <= S_POS;
        end
        S_POS: begin
          pres <= p_rdata[CNT_BITS-1];
          state <= S_DONE;
          case (act)
            ACT_INSERT: begin
              if (p_rdata[CNT_BITS-1]) begin
                status <= ST_PRESENT;
              end else if (count == CNT_BITS'(CAPACITY)) begin
                status <= ST_FULL;
              end else begin
                at <= count[SLOT_BITS-1:0]; cur_v <= vid; cur_d <= key;
                count <= count + CNT_BITS'(1); pres <= 1'b1;
                state <= S_UP;
              end
            end
            ACT_EXTRACT: begin
              if (count == '0) status <= ST_EMPTY;
              else state <= S_XROOT;
            end
            ACT_DECREASE: begin
              if (!p_rdata[CNT_BITS-1]) begin
                status <= ST_ABSENT;
              end else begin
                at <= p_rdata[SLOT_BITS-1:0];
                state <= S_DREAD;
              end
            end
            default: ;
          endcase
        end
        S_DREAD: begin
          if (lt) begin
            cur_v <= vid; cur_d <= key;
            state <= S_UP;
          end else begin
            status <= ST_NOTSMALL;
            state <= S_DONE;
          end
        end
        S_XROOT: begin
          ov <= rd_v; od <= rd_d;
          if (rd_v == vid) pres <= 1'b0;
          count <= count - CNT_BITS'(1);
          state <= S_XLAST;
        end
        S_XLAST: begin
          if (count == '0) begin
            state <= S_DONE;
          end else begin
            cur_v <= rd_v; cur_d <= rd_d; at <= '0;
            state <= S_DN;
          end
        end
        S_UP: begin
          if (at == '0) state <= S_PUT;
          else state <= S_UPC;
        end
        S_UPC: begin
          if (lt) begin
            at <= parent;
            state <= S_UP;
          end else begin
            state <= S_PUT;
          end
        end
        S_DN: begin
          if (has_lc) state <= S_DNL;
          else state <= S_PUT;
        end
        S_DNL: begin
          if (has_rc) begin
            oth_v <= rd_v; oth_d <= rd_d; lwin <= lt;
            state <= S_DNR;
          end else if (lt) begin
            at <= lc[SLOT_BITS-1:0];
            state <= S_DN;
          end else begin
            state <= S_PUT;
          end
        end
        S_DNR: begin
          if (lt) begin
            at <= rc[SLOT_BITS-1:0];
            state <= S_DN;
          end else if (lwin) begin
            at <= lc[SLOT_BITS-1:0];
            state <= S_DN;
          end else begin
            state <= S_PUT;
          end
        end
        S_PUT:  state <= S_DONE;
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res_in = '{status: status, vertex: ov, distance: od, present: pres, count: count};

  imh_out_reg u_out (
    .clk(clk), .rst(rst), .load(res_load), .load_data(res_in),
    .full(res_full), .take(m_axis_tready), .data(res_q)
  );
  assign m_axis_tvalid = res_full;
  assign m_axis_tdata  = {7'd0, res_q.count, res_q.present, res_q.distance,
                          res_q.vertex, res_q.status};

  assert property (@(posedge clk) disable iff (rst) count <= CNT_BITS'(CAPACITY))
    else $error("entry count above capacity");
  assert property (@(posedge clk) disable iff (rst) !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result waits");
  assert property (@(posedge clk) disable iff (rst) res_load |-> !res_full)
    else $error("result loaded over a waiting one");
endmodule
`default_nettype wire
